>>> src/pps_pkg.sv
// shared types, field widths and codes for the preemptive priority scheduler
package pps_pkg;

    localparam int ARR_W   = 16;
    localparam int BURST_W = 16;
    localparam int PRIO_W  = 8;
    localparam int PIDX_W  = 4;
    localparam int OTIME_W = 21;
    localparam int SUM_W   = 25;
    localparam int STAT_W  = 2;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_RUN  = 1'b1;

    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_DROPPED = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY   = 2'd2;

    typedef struct packed {
        logic               cmd;
        logic [ARR_W-1:0]   arrival_time;
        logic [BURST_W-1:0] burst_time;
        logic [PRIO_W-1:0]  prio_level;
    } pps_job_t;

    typedef struct packed {
        logic [PIDX_W-1:0]  proc_index;
        logic [OTIME_W-1:0] completion_time;
        logic [OTIME_W-1:0] turnaround_time;
        logic [OTIME_W-1:0] waiting_time;
        logic [SUM_W-1:0]   total_turnaround;
        logic [SUM_W-1:0]   total_waiting;
        logic [STAT_W-1:0]  status;
        logic               last;
    } pps_report_t;

    // table write enables
    typedef struct packed {
        logic load;
        logic rem;
        logic fin;
    } pps_wr_t;

endpackage

>>> src/pps_stream_if.sv
// valid/ready channel carrying one word of a given payload type
interface pps_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> src/pps_alu.sv
// shared subtractor with borrow, used for the scheduler's time subtractions
module pps_alu
    import pps_pkg::*;
#(
    parameter int W = 21
) (
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    output logic [W-1:0] diff,
    output logic         borrow
);

    assign {borrow, diff} = {1'b0, a} - {1'b0, b};

endmodule

>>> src/pps_table.sv
// process table: one write port with field enables, one registered read port
module pps_table
    import pps_pkg::*;
#(
    parameter int MAX_PROCS = 16,
    parameter int IDX_W     = 4,
    parameter int TIME_W    = 21
) (
    input  logic                clk,
    input  pps_wr_t             wr,
    input  logic [IDX_W-1:0]    wr_addr,
    input  logic [ARR_W-1:0]    wr_arrival,
    input  logic [BURST_W-1:0]  wr_burst,
    input  logic [BURST_W-1:0]  wr_rem,
    input  logic [PRIO_W-1:0]   wr_prio,
    input  logic [TIME_W-1:0]   wr_finish,
    input  logic [IDX_W-1:0]    rd_addr,
    output logic [ARR_W-1:0]    rd_arrival,
    output logic [BURST_W-1:0]  rd_burst,
    output logic [BURST_W-1:0]  rd_rem,
    output logic [PRIO_W-1:0]   rd_prio,
    output logic [TIME_W-1:0]   rd_finish
);

    logic [ARR_W-1:0]   arrival_mem [MAX_PROCS];
    logic [BURST_W-1:0] burst_mem   [MAX_PROCS];
    logic [BURST_W-1:0] rem_mem     [MAX_PROCS];
    logic [PRIO_W-1:0]  prio_mem    [MAX_PROCS];
    logic [TIME_W-1:0]  finish_mem  [MAX_PROCS];

    always_ff @(posedge clk)
    begin
        if (wr.load)
        begin
            arrival_mem[wr_addr] <= wr_arrival;
            burst_mem[wr_addr]   <= wr_burst;
            prio_mem[wr_addr]    <= wr_prio;
        end
        if (wr.load || wr.rem)
        begin
            rem_mem[wr_addr] <= wr_rem;
        end
        if (wr.fin)
        begin
            finish_mem[wr_addr] <= wr_finish;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_arrival <= arrival_mem[rd_addr];
        rd_burst   <= burst_mem[rd_addr];
        rd_rem     <= rem_mem[rd_addr];
        rd_prio    <= prio_mem[rd_addr];
        rd_finish  <= finish_mem[rd_addr];
    end

endmodule

>>> src/pps_seq.sv
// sequencer: loads, event-driven schedule scan and per-process report
module pps_seq
    import pps_pkg::*;
#(
    parameter int MAX_PROCS = 16,
    parameter int IDX_W     = 4,
    parameter int CNT_W     = 5,
    parameter int TIME_W    = 21
) (
    input  logic               clk,
    input  logic               rst_n,
    pps_stream_if.sink         job,
    pps_stream_if.source       report,
    // table
    output pps_wr_t            wr,
    output logic [IDX_W-1:0]   wr_addr,
    output logic [ARR_W-1:0]   wr_arrival,
    output logic [BURST_W-1:0] wr_burst,
    output logic [BURST_W-1:0] wr_rem,
    output logic [PRIO_W-1:0]  wr_prio,
    output logic [TIME_W-1:0]  wr_finish,
    output logic [IDX_W-1:0]   rd_addr,
    input  logic [ARR_W-1:0]   rd_arrival,
    input  logic [BURST_W-1:0] rd_burst,
    input  logic [BURST_W-1:0] rd_rem,
    input  logic [PRIO_W-1:0]  rd_prio,
    input  logic [TIME_W-1:0]  rd_finish,
    // shared subtractor
    output logic [TIME_W-1:0]  alu_a,
    output logic [TIME_W-1:0]  alu_b,
    input  logic [TIME_W-1:0]  alu_diff,
    input  logic               alu_borrow
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_ADVANCE,
        S_RD,
        S_TURN,
        S_WAIT,
        S_SEND
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 dropped_reg, dropped_next;
    logic [MAX_PROCS-1:0] done_reg, done_next;
    logic [TIME_W-1:0]    time_reg, time_next;
    logic [CNT_W-1:0]     fin_reg, fin_next;
    logic [STAT_W-1:0]    status_reg, status_next;
    logic [CNT_W-1:0]     iss_reg, iss_next;
    logic                 chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0]     chk_idx_reg, chk_idx_next;
    logic                 cand_vld_reg, cand_vld_next;
    logic [IDX_W-1:0]     cand_idx_reg, cand_idx_next;
    logic [PRIO_W-1:0]    cand_prio_reg, cand_prio_next;
    logic [BURST_W-1:0]   cand_rem_reg, cand_rem_next;
    logic                 nxt_vld_reg, nxt_vld_next;
    logic [ARR_W-1:0]     nxt_min_reg, nxt_min_next;
    logic [BURST_W-1:0]   gap_reg, gap_next;
    logic [TIME_W-1:0]    turn_reg, turn_next;
    logic [SUM_W-1:0]     tot_turn_reg, tot_turn_next;
    logic [SUM_W-1:0]     tot_wait_reg, tot_wait_next;
    logic [CNT_W-1:0]     out_idx_reg, out_idx_next;
    pps_report_t          rep_reg, rep_next;
    logic                 rep_vld_reg, rep_vld_next;

    logic [BURST_W-1:0]   burst_fix;
    logic [BURST_W-1:0]   new_rem;
    logic [BURST_W-1:0]   dt;
    logic                 is_last;

    assign job.ready    = (state_reg == S_IDLE);
    assign report.valid = rep_vld_reg;
    assign report.data  = rep_reg;

    assign burst_fix = (job.data.burst_time == '0) ? BURST_W'(1) : job.data.burst_time;
    assign is_last   = ((out_idx_reg + CNT_W'(1)) == count_reg);

    // run for the remaining burst or up to the next arrival, whichever is first
    always_comb
    begin
        if (nxt_vld_reg && !alu_borrow && (alu_diff != '0))
        begin
            new_rem = alu_diff[BURST_W-1:0];
            dt      = gap_reg;
        end
        else
        begin
            new_rem = '0;
            dt      = cand_rem_reg;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        dropped_next   = dropped_reg;
        done_next      = done_reg;
        time_next      = time_reg;
        fin_next       = fin_reg;
        status_next    = status_reg;
        iss_next       = iss_reg;
        chk_vld_next   = chk_vld_reg;
        chk_idx_next   = chk_idx_reg;
        cand_vld_next  = cand_vld_reg;
        cand_idx_next  = cand_idx_reg;
        cand_prio_next = cand_prio_reg;
        cand_rem_next  = cand_rem_reg;
        nxt_vld_next   = nxt_vld_reg;
        nxt_min_next   = nxt_min_reg;
        gap_next       = gap_reg;
        turn_next      = turn_reg;
        tot_turn_next  = tot_turn_reg;
        tot_wait_next  = tot_wait_reg;
        out_idx_next   = out_idx_reg;
        rep_next       = rep_reg;
        rep_vld_next   = rep_vld_reg;

        wr         = '0;
        wr_addr    = count_reg[IDX_W-1:0];
        wr_arrival = job.data.arrival_time;
        wr_burst   = burst_fix;
        wr_rem     = burst_fix;
        wr_prio    = job.data.prio_level;
        wr_finish  = time_reg + TIME_W'(dt);
        rd_addr    = (state_reg == S_SCAN) ? iss_reg[IDX_W-1:0] : out_idx_reg[IDX_W-1:0];
        alu_a      = '0;
        alu_b      = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (job.valid)
                begin
                    if (job.data.cmd == CMD_LOAD)
                    begin
                        if (count_reg == CNT_W'(MAX_PROCS))
                        begin
                            dropped_next = 1'b1;
                        end
                        else
                        begin
                            wr.load    = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        rep_next        = '0;
                        rep_next.status = STAT_EMPTY;
                        rep_next.last   = 1'b1;
                        rep_vld_next    = 1'b1;
                        state_next      = S_SEND;
                    end
                    else
                    begin
                        status_next   = dropped_reg ? STAT_DROPPED : STAT_OK;
                        time_next     = '0;
                        fin_next      = '0;
                        cand_vld_next = 1'b0;
                        nxt_vld_next  = 1'b0;
                        iss_next      = '0;
                        chk_vld_next  = 1'b0;
                        state_next    = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                if (chk_vld_reg && !done_reg[chk_idx_reg])
                begin
                    if (TIME_W'(rd_arrival) <= time_reg)
                    begin
                        // the running process is seeded in cand, so ties keep it
                        if (!cand_vld_reg || (cand_prio_reg < rd_prio))
                        begin
                            cand_vld_next  = 1'b1;
                            cand_idx_next  = chk_idx_reg;
                            cand_prio_next = rd_prio;
                            cand_rem_next  = rd_rem;
                        end
                    end
                    else if (!nxt_vld_reg || (rd_arrival < nxt_min_reg))
                    begin
                        nxt_vld_next = 1'b1;
                        nxt_min_next = rd_arrival;
                    end
                end
                if (iss_reg < count_reg)
                begin
                    chk_vld_next = 1'b1;
                    chk_idx_next = iss_reg[IDX_W-1:0];
                    iss_next     = iss_reg + CNT_W'(1);
                end
                else
                begin
                    chk_vld_next = 1'b0;
                    state_next   = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                alu_a    = TIME_W'(nxt_min_reg);
                alu_b    = time_reg;
                gap_next = alu_diff[BURST_W-1:0];
                if (!cand_vld_reg)
                begin
                    // idle: jump to the earliest pending arrival
                    time_next    = TIME_W'(nxt_min_reg);
                    nxt_vld_next = 1'b0;
                    iss_next     = '0;
                    state_next   = S_SCAN;
                end
                else
                begin
                    state_next = S_ADVANCE;
                end
            end

            S_ADVANCE:
            begin
                alu_a        = TIME_W'(cand_rem_reg);
                alu_b        = TIME_W'(gap_reg);
                wr.rem       = 1'b1;
                wr_addr      = cand_idx_reg;
                wr_rem       = new_rem;
                time_next    = time_reg + TIME_W'(dt);
                nxt_vld_next = 1'b0;
                iss_next     = '0;
                state_next   = S_SCAN;
                if (new_rem == '0)
                begin
                    wr.fin                  = 1'b1;
                    done_next[cand_idx_reg] = 1'b1;
                    cand_vld_next           = 1'b0;
                    fin_next                = fin_reg + CNT_W'(1);
                    if ((fin_reg + CNT_W'(1)) == count_reg)
                    begin
                        out_idx_next  = '0;
                        tot_turn_next = '0;
                        tot_wait_next = '0;
                        state_next    = S_RD;
                    end
                end
                else
                begin
                    cand_rem_next = new_rem;
                end
            end

            S_RD:
            begin
                state_next = S_TURN;
            end

            S_TURN:
            begin
                alu_a      = rd_finish;
                alu_b      = TIME_W'(rd_arrival);
                turn_next  = alu_diff;
                state_next = S_WAIT;
            end

            S_WAIT:
            begin
                alu_a         = turn_reg;
                alu_b         = TIME_W'(rd_burst);
                tot_turn_next = tot_turn_reg + SUM_W'(turn_reg);
                tot_wait_next = tot_wait_reg + SUM_W'(alu_diff);
                rep_next.proc_index       = PIDX_W'(out_idx_reg);
                rep_next.completion_time  = OTIME_W'(rd_finish);
                rep_next.turnaround_time  = OTIME_W'(turn_reg);
                rep_next.waiting_time     = OTIME_W'(alu_diff);
                rep_next.total_turnaround = is_last ? tot_turn_next : '0;
                rep_next.total_waiting    = is_last ? tot_wait_next : '0;
                rep_next.status           = status_reg;
                rep_next.last             = is_last;
                rep_vld_next              = 1'b1;
                state_next                = S_SEND;
            end

            S_SEND:
            begin
                if (report.ready)
                begin
                    rep_vld_next = 1'b0;
                    if (rep_reg.last)
                    begin
                        // run over: clear the process count, flags and clock for the next batch
                        count_next    = '0;
                        dropped_next  = 1'b0;
                        done_next     = '0;
                        time_next     = '0;
                        cand_vld_next = 1'b0;
                        cand_idx_next = '0;
                        state_next    = S_IDLE;
                    end
                    else
                    begin
                        out_idx_next = out_idx_reg + CNT_W'(1);
                        state_next   = S_RD;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            dropped_reg  <= 1'b0;
            done_reg     <= '0;
            time_reg     <= '0;
            fin_reg      <= '0;
            iss_reg      <= '0;
            chk_vld_reg  <= 1'b0;
            cand_vld_reg <= 1'b0;
            cand_idx_reg <= '0;
            nxt_vld_reg  <= 1'b0;
            out_idx_reg  <= '0;
            rep_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            dropped_reg  <= dropped_next;
            done_reg     <= done_next;
            time_reg     <= time_next;
            fin_reg      <= fin_next;
            iss_reg      <= iss_next;
            chk_vld_reg  <= chk_vld_next;
            cand_vld_reg <= cand_vld_next;
            cand_idx_reg <= cand_idx_next;
            nxt_vld_reg  <= nxt_vld_next;
            out_idx_reg  <= out_idx_next;
            rep_vld_reg  <= rep_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg    <= status_next;
        chk_idx_reg   <= chk_idx_next;
        cand_prio_reg <= cand_prio_next;
        cand_rem_reg  <= cand_rem_next;
        nxt_min_reg   <= nxt_min_next;
        gap_reg       <= gap_next;
        turn_reg      <= turn_next;
        tot_turn_reg  <= tot_turn_next;
        tot_wait_reg  <= tot_wait_next;
        rep_reg       <= rep_next;
    end

endmodule

>>> src/preemptive_priority_scheduler.sv
// operation: a load word is written while idle; a run makes one table scan on the read port
// per schedule event (at most 3n events: arrivals, idle gaps, completions), then goes through the
// read, turn, wait and send states per report word, plus output stalls; an empty run sends one word
// throughput: one word in flight, ready only between runs and loads
// reset: asynchronous, clears the process count, done flags, drop flag, clock and running
// process; table contents are undefined until loaded
module preemptive_priority_scheduler
    import pps_pkg::*;
#(
    parameter int MAX_PROCS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    pps_stream_if.sink   job,
    pps_stream_if.source report
);

    localparam int IDX_W  = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CNT_W  = $clog2(MAX_PROCS + 1);
    localparam int TIME_W = ARR_W + CNT_W;

    pps_wr_t            wr;
    logic [IDX_W-1:0]   wr_addr;
    logic [ARR_W-1:0]   wr_arrival;
    logic [BURST_W-1:0] wr_burst;
    logic [BURST_W-1:0] wr_rem;
    logic [PRIO_W-1:0]  wr_prio;
    logic [TIME_W-1:0]  wr_finish;
    logic [IDX_W-1:0]   rd_addr;
    logic [ARR_W-1:0]   rd_arrival;
    logic [BURST_W-1:0] rd_burst;
    logic [BURST_W-1:0] rd_rem;
    logic [PRIO_W-1:0]  rd_prio;
    logic [TIME_W-1:0]  rd_finish;
    logic [TIME_W-1:0]  alu_a;
    logic [TIME_W-1:0]  alu_b;
    logic [TIME_W-1:0]  alu_diff;
    logic               alu_borrow;

    pps_table #(
        .MAX_PROCS (MAX_PROCS),
        .IDX_W     (IDX_W),
        .TIME_W    (TIME_W)
    ) u_table (
        .clk        (clk),
        .wr         (wr),
        .wr_addr    (wr_addr),
        .wr_arrival (wr_arrival),
        .wr_burst   (wr_burst),
        .wr_rem     (wr_rem),
        .wr_prio    (wr_prio),
        .wr_finish  (wr_finish),
        .rd_addr    (rd_addr),
        .rd_arrival (rd_arrival),
        .rd_burst   (rd_burst),
        .rd_rem     (rd_rem),
        .rd_prio    (rd_prio),
        .rd_finish  (rd_finish)
    );

    pps_alu #(
        .W (TIME_W)
    ) u_alu (
        .a      (alu_a),
        .b      (alu_b),
        .diff   (alu_diff),
        .borrow (alu_borrow)
    );

    pps_seq #(
        .MAX_PROCS (MAX_PROCS),
        .IDX_W     (IDX_W),
        .CNT_W     (CNT_W),
        .TIME_W    (TIME_W)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .job        (job),
        .report     (report),
        .wr         (wr),
        .wr_addr    (wr_addr),
        .wr_arrival (wr_arrival),
        .wr_burst   (wr_burst),
        .wr_rem     (wr_rem),
        .wr_prio    (wr_prio),
        .wr_finish  (wr_finish),
        .rd_addr    (rd_addr),
        .rd_arrival (rd_arrival),
        .rd_burst   (rd_burst),
        .rd_rem     (rd_rem),
        .rd_prio    (rd_prio),
        .rd_finish  (rd_finish),
        .alu_a      (alu_a),
        .alu_b      (alu_b),
        .alu_diff   (alu_diff),
        .alu_borrow (alu_borrow)
    );

endmodule

>>> dv/pps_schedule_check.sv
`timescale 1ns / 100ps
// checker: predicts the schedule reports from accepted job words and compares them
module pps_schedule_check
    import pps_pkg::*;
#(
    parameter int MAX_PROCS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        job_valid,
    input  logic        job_ready,
    input  pps_job_t    job_data,
    input  logic        report_valid,
    input  logic        report_ready,
    input  pps_report_t report_data,
    output int          fail_count,
    output int          pending
);

    logic [ARR_W-1:0]   arrival_tab [MAX_PROCS];
    logic [BURST_W-1:0] burst_tab   [MAX_PROCS];
    logic [PRIO_W-1:0]  prio_tab    [MAX_PROCS];
    int unsigned        loaded = 0;
    bit                 dropped = 1'b0;

    pps_report_t awaited_reports [$];
    int          mismatches = 0;
    int          outstanding = 0;
    int          reports_seen = 0;

    assign fail_count = mismatches;
    assign pending    = outstanding;

    task automatic report_mismatch(input string what);
        $display("%0t ns: report word %0d: %s", $time, reports_seen, what);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
    endtask

    // play the ticks out event by event: the running process only changes at an
    // arrival or a completion, so it runs until the next of the two
    function automatic void predict_schedule();
        int unsigned        left [MAX_PROCS];
        int unsigned        finish [MAX_PROCS];
        bit [MAX_PROCS-1:0] done;
        int unsigned        now, finished, step, next_arr, turn, wait_t;
        int unsigned        sum_turn, sum_wait;
        int                 cur;
        bit                 busy;
        pps_report_t        r;

        now = 0;
        finished = 0;
        done = '0;
        busy = 1'b0;
        cur = 0;
        sum_turn = 0;
        sum_wait = 0;
        for (int i = 0; i < loaded; i++)
            left[i] = 32'(burst_tab[i]);

        while (finished < loaded)
        begin
            for (int j = 0; j < loaded; j++)
                if (!done[j] && arrival_tab[j] <= now && (!busy || prio_tab[cur] < prio_tab[j]))
                begin
                    cur = j;
                    busy = 1'b1;
                end
            if (!busy)
            begin
                // nothing ready: skip ahead to the earliest pending arrival
                next_arr = 32'hFFFF_FFFF;
                for (int j = 0; j < loaded; j++)
                    if (!done[j] && arrival_tab[j] < next_arr)
                        next_arr = 32'(arrival_tab[j]);
                now = next_arr;
            end
            else
            begin
                step = left[cur];
                for (int j = 0; j < loaded; j++)
                    if (!done[j] && arrival_tab[j] > now && arrival_tab[j] - now < step)
                        step = 32'(arrival_tab[j]) - now;
                left[cur] -= step;
                now += step;
                if (left[cur] == 0)
                begin
                    finish[cur] = now;
                    done[cur] = 1'b1;
                    busy = 1'b0;
                    finished++;
                end
            end
        end

        for (int i = 0; i < loaded; i++)
        begin
            turn = finish[i] - 32'(arrival_tab[i]);
            wait_t = turn - 32'(burst_tab[i]);
            sum_turn += turn;
            sum_wait += wait_t;
            r = '0;
            r.proc_index = PIDX_W'(i);
            r.completion_time = OTIME_W'(finish[i]);
            r.turnaround_time = OTIME_W'(turn);
            r.waiting_time = OTIME_W'(wait_t);
            r.status = dropped ? STAT_DROPPED : STAT_OK;
            if (i == loaded - 1)
            begin
                r.total_turnaround = SUM_W'(sum_turn);
                r.total_waiting = SUM_W'(sum_wait);
                r.last = 1'b1;
            end
            awaited_reports.push_back(r);
        end
    endfunction

    function automatic void take_job(input pps_job_t w);
        pps_report_t r;

        if (w.cmd == CMD_LOAD)
        begin
            if (loaded >= MAX_PROCS)
                dropped = 1'b1;
            else
            begin
                arrival_tab[loaded] = w.arrival_time;
                burst_tab[loaded] = (w.burst_time == '0) ? BURST_W'(1) : w.burst_time;
                prio_tab[loaded] = w.prio_level;
                loaded++;
            end
        end
        else
        begin
            if (loaded == 0)
            begin
                r = '0;
                r.status = STAT_EMPTY;
                r.last = 1'b1;
                awaited_reports.push_back(r);
            end
            else
                predict_schedule();
            loaded = 0;
            dropped = 1'b0;
        end
    endfunction

    task automatic compare_report(input pps_report_t got);
        pps_report_t want;

        reports_seen++;
        if (awaited_reports.size() == 0)
        begin
            report_mismatch("report word with none expected");
            return;
        end
        want = awaited_reports.pop_front();
        check_field("proc_index", 32'(got.proc_index), 32'(want.proc_index));
        check_field("completion_time", 32'(got.completion_time), 32'(want.completion_time));
        check_field("turnaround_time", 32'(got.turnaround_time), 32'(want.turnaround_time));
        check_field("waiting_time", 32'(got.waiting_time), 32'(want.waiting_time));
        check_field("total_turnaround", 32'(got.total_turnaround),
                    32'(want.total_turnaround));
        check_field("total_waiting", 32'(got.total_waiting), 32'(want.total_waiting));
        check_field("status", 32'(got.status), 32'(want.status));
        check_field("last", 32'(got.last), 32'(want.last));
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (job_valid && job_ready)
                take_job(job_data);
            if (report_valid && report_ready)
                compare_report(report_data);
        end
        outstanding = awaited_reports.size();
    end

endmodule

>>> dv/testbench.sv
`timescale 1ns / 100ps
// testbench top: clock, reset, job stimulus, report back-pressure and the verdict
module testbench;
    import pps_pkg::*;

    localparam int PROCS = 16;

    logic clk = 1'b0;
    logic rst_n;
    int   job_gap = 22;
    int   ready_idle = 61;
    int   words_sent = 0;
    int   fail_count;
    int   pending;

    pps_stream_if #(.payload_t(pps_job_t))    job_ch ();
    pps_stream_if #(.payload_t(pps_report_t)) report_ch ();

    preemptive_priority_scheduler #(
        .MAX_PROCS(PROCS)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .job    (job_ch),
        .report (report_ch)
    );

    pps_schedule_check #(
        .MAX_PROCS(PROCS)
    ) checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (job_ch.valid),
        .job_ready    (job_ch.ready),
        .job_data     (job_ch.data),
        .report_valid (report_ch.valid),
        .report_ready (report_ch.ready),
        .report_data  (report_ch.data),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    always #5 clk = ~clk;

    always @(negedge clk)
        report_ch.ready <= ($urandom_range(99) >= ready_idle);

    initial
    begin
        #5_000_000;
        $display("preemptive_priority_scheduler verification failed");
        $finish;
    end

    function automatic pps_job_t make_job(input logic c, input logic [ARR_W-1:0] a,
                                          input logic [BURST_W-1:0] b,
                                          input logic [PRIO_W-1:0] p);
        pps_job_t w;

        w.cmd = c;
        w.arrival_time = a;
        w.burst_time = b;
        w.prio_level = p;
        return w;
    endfunction

    // mostly small values so processes overlap and priorities tie
    function automatic pps_job_t random_load();
        int unsigned ra, rb, rp;
        logic [ARR_W-1:0]   a;
        logic [BURST_W-1:0] b;
        logic [PRIO_W-1:0]  p;

        ra = $urandom_range(9);
        rb = $urandom_range(9);
        rp = $urandom_range(9);
        a = (ra == 0) ? ARR_W'($urandom) : (ra < 3) ? ARR_W'($urandom_range(300))
                                                    : ARR_W'($urandom_range(40));
        b = (rb == 0) ? BURST_W'($urandom) : (rb < 3) ? BURST_W'($urandom_range(200))
                                                      : BURST_W'($urandom_range(12));
        p = (rp < 2) ? PRIO_W'($urandom) : PRIO_W'($urandom_range(3));
        return make_job(CMD_LOAD, a, b, p);
    endfunction

    task automatic send_job(input pps_job_t w);
        @(negedge clk);
        while ($urandom_range(99) < job_gap)
        begin
            job_ch.valid <= 1'b0;
            @(negedge clk);
        end
        job_ch.valid <= 1'b1;
        job_ch.data <= w;
        do @(posedge clk); while (!job_ch.ready);
        words_sent++;
        // receiver-heavy stalls first, then sender-heavy gaps, then full speed
        if (words_sent == 80)
        begin
            job_gap = 61;
            ready_idle = 22;
        end
        else if (words_sent == 160)
        begin
            job_gap = 0;
            ready_idle = 0;
        end
    endtask

    task automatic send_run();
        send_job(make_job(CMD_RUN, ARR_W'($urandom), BURST_W'($urandom), PRIO_W'($urandom)));
    endtask

    initial
    begin
        int k;
        int n;

        rst_n = 1'b0;
        job_ch.valid = 1'b0;
        job_ch.data = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // run on an empty table
        send_run();

        // field extremes, zero burst, arrival at the very end
        send_job(make_job(CMD_LOAD, 16'hFFFF, 16'h0000, 8'hFF));
        send_job(make_job(CMD_LOAD, 16'h0000, 16'hFFFF, 8'h00));
        send_run();

        // idle start, preemption, equal-priority pick by index, idle gap
        send_job(make_job(CMD_LOAD, 16'd4, 16'd5, 8'd3));
        send_job(make_job(CMD_LOAD, 16'd6, 16'd4, 8'd7));
        send_job(make_job(CMD_LOAD, 16'd6, 16'd3, 8'd7));
        send_job(make_job(CMD_LOAD, 16'd7, 16'd2, 8'd9));
        send_job(make_job(CMD_LOAD, 16'd5, 16'd0, 8'd3));
        send_job(make_job(CMD_LOAD, 16'd40, 16'd1, 8'd1));
        send_run();

        // equal priority arriving later does not take over
        send_job(make_job(CMD_LOAD, 16'd0, 16'd4, 8'd5));
        send_job(make_job(CMD_LOAD, 16'd1, 16'd2, 8'd5));
        send_job(make_job(CMD_LOAD, 16'h5555, 16'hAAAA, 8'hA5));
        send_run();

        k = 0;
        while (words_sent < 210)
        begin
            // some sets overflow the table, a few runs find it empty
            if (k % 6 == 1)
                n = $urandom_range(19, 17);
            else if (k % 11 == 5)
                n = 0;
            else
                n = $urandom_range(16, 1);
            repeat (n) send_job(random_load());
            send_run();
            k++;
        end

        @(negedge clk);
        job_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);

        if (fail_count == 0)
            $display("preemptive_priority_scheduler verification clean");
        else
            $display("preemptive_priority_scheduler verification failed");
        $finish;
    end

endmodule
